@@ rtl/fbsa_pkg.sv @@
`timescale 1ns / 1ps
// Package for the fragment burst session ARQ core: item types, codes and constants.
// Used by the channel interfaces, all RTL modules and the checker. No dependencies.
package fbsa_pkg;

    // Input opcodes
    localparam logic [2:0] OP_START     = 3'd0;
    localparam logic [2:0] OP_SEND_DONE = 3'd1;
    localparam logic [2:0] OP_FRAME     = 3'd2;
    localparam logic [2:0] OP_MALFORMED = 3'd3;
    localparam logic [2:0] OP_TICK      = 3'd4;

    // Result actions
    localparam logic [1:0] ACT_HELLO    = 2'd0;
    localparam logic [1:0] ACT_FRAGMENT = 2'd1;
    localparam logic [1:0] ACT_ENDED    = 2'd2;

    // Session outcomes
    localparam logic [2:0] OUT_ACKED       = 3'd0;
    localparam logic [2:0] OUT_PARTIAL     = 3'd1;
    localparam logic [2:0] OUT_BUSY        = 3'd2;
    localparam logic [2:0] OUT_REJECTED    = 3'd3;
    localparam logic [2:0] OUT_NO_RESPONSE = 3'd4;
    localparam logic [2:0] OUT_MALFORMED   = 3'd5;
    localparam logic [2:0] OUT_RADIO_FAULT = 3'd6;

    // Hello acknowledge status
    localparam logic [1:0] HS_READY = 2'd0;
    localparam logic [1:0] HS_BUSY  = 2'd1;

    // Configuration register indexes
    localparam logic [1:0] CFG_GATEWAY_ID    = 2'd0;
    localparam logic [1:0] CFG_HELLO_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_ACK_TIMEOUT   = 2'd2;
    localparam logic [1:0] CFG_INNER_RETRIES = 2'd3;

    // Configuration reset values
    localparam logic [15:0] RST_GATEWAY_ID    = 16'd0;
    localparam logic [15:0] RST_HELLO_TIMEOUT = 16'd2000;
    localparam logic [15:0] RST_ACK_TIMEOUT   = 16'd3000;
    localparam logic [3:0]  RST_INNER_RETRIES = 4'd2;

    localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

    // Session phases
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HELLO_TX,
        PH_HELLO_WAIT,
        PH_FRAG_TX,
        PH_ACK_WAIT
    } t_phase;

    // Event class worked out by the front end
    typedef enum logic [2:0] {
        KIND_START,
        KIND_SEND_DONE,
        KIND_FRAME,
        KIND_MALFORMED,
        KIND_TICK,
        KIND_IGNORE
    } t_kind;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  start_seq;
        logic        is_retry;
        logic        radio_ok;
        logic [15:0] frame_src;
        logic [7:0]  frame_seq;
        logic        parse_ok;
        logic [1:0]  hello_status;
        logic [15:0] acked_mask;
        logic        has_config;
        logic        config_valid;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  fragment_index;
        logic [7:0]  session_seq_out;
        logic        retry_flag;
        logic [2:0]  outcome;
        logic        config_ready;
        logic [15:0] mask_status;
    } t_out_item;

    // Queue entry: classified event with the fields the back end needs
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  start_seq;
        logic        is_retry;
        logic        radio_ok;
        logic [15:0] frame_src;
        logic [7:0]  frame_seq;
        logic        parse_ok;
        logic [1:0]  hello_status;
        logic [15:0] acked_mask;
        logic        has_config;
        logic        config_valid;
    } t_entry;

    // Head of the event queue as seen by the back end
    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_head;

    // Configuration write
    typedef struct packed {
        logic        we;
        logic [1:0]  idx;
        logic [15:0] data;
    } t_cfg_wr;

endpackage

@@ rtl/fbsa_ifs.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the input events and the results.
// Depends on fbsa_pkg for the payload types.
interface fbsa_in_if import fbsa_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface fbsa_out_if import fbsa_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/fragment_burst_session_arq_core.sv @@
`timescale 1ns / 1ps
// An accepted event goes through the event queue and then the result register.
// Throughput: one event per cycle unless the result side stalls; the two-entry event
// queue and the result register let the input and output sides stall independently.
// Reset: synchronous, active low; clears the session state, the received-fragment mask,
// the queue and the result register, and restores configuration defaults.
module fragment_burst_session_arq_core import fbsa_pkg::*; #(
    parameter int FRAGMENTS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fbsa_in_if.sink      i_in,
    fbsa_out_if.source   o_out,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [15:0]  i_cfg_data
);

    t_head   w_head;
    logic    w_pop;
    t_cfg_wr w_cfg;

    assign w_cfg.we   = i_cfg_we;
    assign w_cfg.idx  = i_cfg_idx;
    assign w_cfg.data = i_cfg_data;

    // Accept and classify events
    fbsa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    // Run the session and hold the result
    fbsa_back #(
        .FRAGMENTS (FRAGMENTS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .i_cfg   (w_cfg),
        .o_out   (o_out)
    );

endmodule

@@ rtl/fbsa_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts input transactions, classifies the opcode and queues events.
// Depends on fbsa_pkg and fbsa_in_if.
module fbsa_front import fbsa_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fbsa_in_if.sink      i_in,
    input  logic         i_pop,
    output t_head        o_head
);

    t_entry     r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_push;
    t_entry     n_entry;

    // Map the opcode onto an event class; unused codes are dropped by the back end
    function automatic t_kind classify(input logic [2:0] op);
        t_kind k;
        case (op)
            OP_START:     k = KIND_START;
            OP_SEND_DONE: k = KIND_SEND_DONE;
            OP_FRAME:     k = KIND_FRAME;
            OP_MALFORMED: k = KIND_MALFORMED;
            OP_TICK:      k = KIND_TICK;
            default:      k = KIND_IGNORE;
        endcase
        return k;
    endfunction

    assign i_in.ready = (r_count != 2'd2);
    assign n_push     = i_in.valid & i_in.ready;

    // Build the queue entry from the incoming transaction
    always_comb begin
        n_entry.kind         = classify(i_in.payload.opcode);
        n_entry.start_seq    = i_in.payload.start_seq;
        n_entry.is_retry     = i_in.payload.is_retry;
        n_entry.radio_ok     = i_in.payload.radio_ok;
        n_entry.frame_src    = i_in.payload.frame_src;
        n_entry.frame_seq    = i_in.payload.frame_seq;
        n_entry.parse_ok     = i_in.payload.parse_ok;
        n_entry.hello_status = i_in.payload.hello_status;
        n_entry.acked_mask   = i_in.payload.acked_mask;
        n_entry.has_config   = i_in.payload.has_config;
        n_entry.config_valid = i_in.payload.config_valid;
    end

    // Queue storage; payload needs no reset
    always_ff @(posedge i_clk) begin
        if (n_push) begin
            r_q[r_wr_ptr] <= n_entry;
        end
    end

    // Queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (n_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({n_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.entry = r_q[r_rd_ptr];

endmodule

@@ rtl/fbsa_back.sv @@
`timescale 1ns / 1ps
// Back end: session state machine, configuration registers and the result register.
// Depends on fbsa_pkg and fbsa_out_if; takes events from fbsa_front.
module fbsa_back import fbsa_pkg::*; #(
    parameter int FRAGMENTS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_head        i_head,
    output logic         o_pop,
    input  t_cfg_wr      i_cfg,
    fbsa_out_if.source   o_out
);

    localparam logic [15:0] FULL_MASK = 16'((32'd1 << FRAGMENTS) - 32'd1);

    // Configuration
    logic [15:0] r_gateway_id;
    logic [15:0] r_hello_timeout;
    logic [15:0] r_ack_timeout;
    logic [3:0]  r_inner_retries;

    // Session state
    t_phase      r_phase,   n_phase;
    logic [7:0]  r_seq,     n_seq;
    logic [15:0] r_mask,    n_mask;
    logic [3:0]  r_cur,     n_cur;
    logic [3:0]  r_round,   n_round;
    logic [15:0] r_elapsed, n_elapsed;
    logic        r_noise,   n_noise;

    // Result register
    logic        r_out_valid;
    t_out_item   r_out;
    logic        n_res_valid;
    t_out_item   n_res;

    logic        n_fire;
    logic        n_waiting;
    logic [15:0] n_merged;
    logic [15:0] n_round_mask;
    logic [4:0]  n_pick_next;
    logic [4:0]  n_pick_round;
    logic [15:0] n_elapsed_inc;
    logic [15:0] n_limit;
    t_entry      e;

    // Lowest missing fragment at or above 'from'; bit 4 set when there is none
    function automatic logic [4:0] pick(input logic [15:0] m, input logic [4:0] from);
        logic [4:0] r;
        r = 5'h10;
        for (int i = 15; i >= 0; i--) begin
            if (i < FRAGMENTS && 5'(i) >= from && !m[i]) begin
                r = {1'b0, 4'(i)};
            end
        end
        return r;
    endfunction

    assign e         = i_head.entry;
    assign n_fire    = i_head.valid & (~r_out_valid | o_out.ready);
    assign o_pop     = n_fire;
    assign n_waiting = (r_phase == PH_HELLO_WAIT) || (r_phase == PH_ACK_WAIT);

    // Fragment pickers: continue within a round, or open a round from index zero
    assign n_merged      = (r_mask | e.acked_mask) & FULL_MASK;
    assign n_round_mask  = (r_phase == PH_ACK_WAIT) ? n_merged : r_mask;
    assign n_pick_next   = pick(r_mask, {1'b0, r_cur} + 5'd1);
    assign n_pick_round  = pick(n_round_mask, 5'd0);
    assign n_elapsed_inc = (r_elapsed != ELAPSED_MAX) ? r_elapsed + 16'd1 : r_elapsed;
    assign n_limit       = (r_phase == PH_HELLO_WAIT) ? r_hello_timeout : r_ack_timeout;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gateway_id    <= RST_GATEWAY_ID;
            r_hello_timeout <= RST_HELLO_TIMEOUT;
            r_ack_timeout   <= RST_ACK_TIMEOUT;
            r_inner_retries <= RST_INNER_RETRIES;
        end else if (i_cfg.we) begin
            case (i_cfg.idx)
                CFG_GATEWAY_ID:    r_gateway_id    <= i_cfg.data;
                CFG_HELLO_TIMEOUT: r_hello_timeout <= i_cfg.data;
                CFG_ACK_TIMEOUT:   r_ack_timeout   <= i_cfg.data;
                CFG_INNER_RETRIES: r_inner_retries <= i_cfg.data[3:0];
                default:           r_gateway_id    <= r_gateway_id;
            endcase
        end
    end

    // Next state and result for the event at the head of the queue
    always_comb begin
        n_phase     = r_phase;
        n_seq       = r_seq;
        n_mask      = r_mask;
        n_cur       = r_cur;
        n_round     = r_round;
        n_elapsed   = r_elapsed;
        n_noise     = r_noise;
        n_res_valid = 1'b0;
        n_res       = '0;

        if (n_fire) begin
            case (e.kind)
                KIND_START: begin
                    n_seq     = e.start_seq;
                    n_cur     = 4'd0;
                    n_round   = 4'd0;
                    n_elapsed = 16'd0;
                    n_noise   = 1'b0;
                    n_res_valid = 1'b1;
                    if (!e.radio_ok) begin
                        n_phase       = PH_IDLE;
                        n_res.action  = ACT_ENDED;
                        n_res.outcome = OUT_RADIO_FAULT;
                    end else begin
                        n_phase          = PH_HELLO_TX;
                        n_res.action     = ACT_HELLO;
                        n_res.retry_flag = e.is_retry;
                    end
                end
                KIND_SEND_DONE: begin
                    if (r_phase == PH_HELLO_TX || r_phase == PH_FRAG_TX) begin
                        if (!e.radio_ok) begin
                            n_phase       = PH_IDLE;
                            n_res_valid   = 1'b1;
                            n_res.action  = ACT_ENDED;
                            n_res.outcome = OUT_RADIO_FAULT;
                        end else if (r_phase == PH_HELLO_TX || n_pick_next[4]) begin
                            n_phase   = (r_phase == PH_HELLO_TX) ? PH_HELLO_WAIT
                                                                 : PH_ACK_WAIT;
                            n_elapsed = 16'd0;
                            n_noise   = 1'b0;
                        end else begin
                            n_cur                = n_pick_next[3:0];
                            n_res_valid          = 1'b1;
                            n_res.action         = ACT_FRAGMENT;
                            n_res.fragment_index = n_pick_next[3:0];
                        end
                    end
                end
                KIND_FRAME: begin
                    if (n_waiting) begin
                        if (e.frame_src != r_gateway_id || e.frame_seq != r_seq) begin
                            // Foreign or stale frame: remember it as noise
                            n_noise = 1'b1;
                        end else if (!e.parse_ok) begin
                            n_phase       = PH_IDLE;
                            n_res_valid   = 1'b1;
                            n_res.action  = ACT_ENDED;
                            n_res.outcome = OUT_MALFORMED;
                        end else if (r_phase == PH_HELLO_WAIT && e.hello_status != HS_READY) begin
                            n_phase       = PH_IDLE;
                            n_res_valid   = 1'b1;
                            n_res.action  = ACT_ENDED;
                            n_res.outcome = (e.hello_status == HS_BUSY) ? OUT_BUSY
                                                                        : OUT_REJECTED;
                        end else if (r_phase == PH_ACK_WAIT && n_merged == FULL_MASK) begin
                            // Everything landed: the mask starts afresh
                            n_mask             = 16'd0;
                            n_phase            = PH_IDLE;
                            n_res_valid        = 1'b1;
                            n_res.action       = ACT_ENDED;
                            n_res.outcome      = OUT_ACKED;
                            n_res.config_ready = e.has_config & e.config_valid;
                        end else if (r_phase == PH_ACK_WAIT && r_round >= r_inner_retries) begin
                            n_mask        = n_merged;
                            n_phase       = PH_IDLE;
                            n_res_valid   = 1'b1;
                            n_res.action  = ACT_ENDED;
                            n_res.outcome = OUT_PARTIAL;
                        end else begin
                            // Start a new fragment round
                            n_mask  = n_round_mask;
                            n_round = (r_phase == PH_ACK_WAIT) ? r_round + 4'd1 : 4'd0;
                            if (n_pick_round[4]) begin
                                n_phase   = PH_ACK_WAIT;
                                n_elapsed = 16'd0;
                                n_noise   = 1'b0;
                            end else begin
                                n_phase              = PH_FRAG_TX;
                                n_cur                = n_pick_round[3:0];
                                n_res_valid          = 1'b1;
                                n_res.action         = ACT_FRAGMENT;
                                n_res.fragment_index = n_pick_round[3:0];
                            end
                        end
                    end
                end
                KIND_MALFORMED: begin
                    if (n_waiting) begin
                        n_noise = 1'b1;
                    end
                end
                KIND_TICK: begin
                    if (n_waiting) begin
                        n_elapsed = n_elapsed_inc;
                        if (n_elapsed_inc >= n_limit) begin
                            n_phase       = PH_IDLE;
                            n_res_valid   = 1'b1;
                            n_res.action  = ACT_ENDED;
                            n_res.outcome = r_noise ? OUT_MALFORMED : OUT_NO_RESPONSE;
                        end
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end

        // Sequence and mask always reflect the state after the step
        n_res.session_seq_out = n_seq;
        n_res.mask_status     = n_mask;
    end

    // Session state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_seq     <= 8'd0;
            r_mask    <= 16'd0;
            r_cur     <= 4'd0;
            r_round   <= 4'd0;
            r_elapsed <= 16'd0;
            r_noise   <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_seq     <= n_seq;
            r_mask    <= n_mask;
            r_cur     <= n_cur;
            r_round   <= n_round;
            r_elapsed <= n_elapsed;
            r_noise   <= n_noise;
        end
    end

    // Result register: loads on a producing event, empties when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (n_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_res_valid) begin
            r_out <= n_res;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

endmodule

@@ rtl/fbsa_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for fragment_burst_session_arq_core, attached with a bind.
// Depends on fbsa_pkg for the result type and codes.
module fbsa_checker import fbsa_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_item
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn while stalled");

    // A stalled result does not change
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_item))
        else $error("result changed while stalled");

    // Outcome and configuration flag only accompany an ended session
    a_outcome_only_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_item.action != ACT_ENDED |->
            i_out_item.outcome == OUT_ACKED && !i_out_item.config_ready)
        else $error("outcome fields set on a send request");

    // A configuration update only comes with a full acknowledge, which clears the mask
    a_config_on_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_item.config_ready |->
            i_out_item.action == ACT_ENDED && i_out_item.outcome == OUT_ACKED &&
            i_out_item.mask_status == 16'h0000)
        else $error("configuration ready without full acknowledge");

    // A fragment is only sent when it is not yet marked received
    a_fragment_missing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_item.action == ACT_FRAGMENT |->
            !i_out_item.mask_status[i_out_item.fragment_index])
        else $error("fragment requested that is already received");

endmodule

bind fragment_burst_session_arq_core fbsa_checker u_fbsa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_item  (o_out.payload)
);

@@ tb/sv/fragment_burst_session_arq_core_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for fragment_burst_session_arq_core: directed sessions, then random ones.
// Depends on fbsa_pkg, the channel interfaces in fbsa_ifs.sv and the core itself.
module fragment_burst_session_arq_core_tb;
    import fbsa_pkg::*;

    localparam int          NFRAG         = 16;
    localparam logic [15:0] ALL_RECEIVED  = 16'hFFFF;
    localparam logic [1:0]  HS_REJECTED   = 2'd2;
    localparam logic [1:0]  HS_RESERVED   = 2'd3;
    localparam int          SETTLE_CYCLES = 8;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [15:0] cfg_data;

    fbsa_in_if  ev_ch ();
    fbsa_out_if res_ch ();

    int        error_count = 0;
    bit        steady = 1'b0;
    t_out_item pending_results[$];
    t_out_item got_res;
    t_out_item want_res;

    // Our own copy of the registers and of the session state.
    logic [15:0] cfg_gateway;
    logic [15:0] cfg_hello_to;
    logic [15:0] cfg_ack_to;
    logic [3:0]  cfg_retries;
    t_phase      m_phase;
    logic [7:0]  m_seq;
    logic [15:0] m_mask;
    logic [3:0]  m_frag;
    logic [3:0]  m_round;
    logic [15:0] m_elapsed;
    bit          m_noise;

    fragment_burst_session_arq_core #(.FRAGMENTS(NFRAG)) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (ev_ch),
        .o_out      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #20ms;
        $display("fragment_burst_session_arq_core test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Session predictor
    // ------------------------------------------------------------------

    function automatic void reset_session_model();
        cfg_gateway  = RST_GATEWAY_ID;
        cfg_hello_to = RST_HELLO_TIMEOUT;
        cfg_ack_to   = RST_ACK_TIMEOUT;
        cfg_retries  = RST_INNER_RETRIES;
        m_phase      = PH_IDLE;
        m_seq        = '0;
        m_mask       = '0;
        m_frag       = '0;
        m_round      = '0;
        m_elapsed    = '0;
        m_noise      = 1'b0;
    endfunction

    function automatic int first_missing(input int from);
        for (int i = from; i < NFRAG; i++) begin
            if (!m_mask[i]) return i;
        end
        return NFRAG;
    endfunction

    // Every result carries the session sequence and the mask as it stands.
    function automatic t_out_item blank_result(input logic [1:0] act);
        t_out_item r;
        r = '0;
        r.action          = act;
        r.session_seq_out = m_seq;
        r.mask_status     = m_mask;
        return r;
    endfunction

    function automatic t_out_item close_session(input logic [2:0] code);
        t_out_item r;
        m_phase   = PH_IDLE;
        r         = blank_result(ACT_ENDED);
        r.outcome = code;
        return r;
    endfunction

    function automatic void open_window(input t_phase ph);
        m_phase   = ph;
        m_elapsed = '0;
        m_noise   = 1'b0;
    endfunction

    // Picks the next fragment still missing, or moves on to the acknowledge wait.
    function automatic bit next_fragment(input int from, output t_out_item r);
        int f;
        f = first_missing(from);
        r = '0;
        if (f >= NFRAG) begin
            open_window(PH_ACK_WAIT);
            return 1'b0;
        end
        m_frag           = 4'(f);
        m_phase          = PH_FRAG_TX;
        r                = blank_result(ACT_FRAGMENT);
        r.fragment_index = m_frag;
        return 1'b1;
    endfunction

    function automatic bit predict_event(input t_in_item ev, output t_out_item r);
        bit          waiting;
        logic [15:0] limit;
        waiting = (m_phase == PH_HELLO_WAIT) || (m_phase == PH_ACK_WAIT);
        r = '0;
        case (ev.opcode)
            OP_START: begin
                m_seq     = ev.start_seq;
                m_frag    = '0;
                m_round   = '0;
                m_elapsed = '0;
                m_noise   = 1'b0;
                if (!ev.radio_ok) begin
                    r = close_session(OUT_RADIO_FAULT);
                    return 1'b1;
                end
                m_phase      = PH_HELLO_TX;
                r            = blank_result(ACT_HELLO);
                r.retry_flag = ev.is_retry;
                return 1'b1;
            end
            OP_SEND_DONE: begin
                if (m_phase == PH_HELLO_TX) begin
                    if (!ev.radio_ok) begin
                        r = close_session(OUT_RADIO_FAULT);
                        return 1'b1;
                    end
                    open_window(PH_HELLO_WAIT);
                    return 1'b0;
                end
                if (m_phase == PH_FRAG_TX) begin
                    if (!ev.radio_ok) begin
                        r = close_session(OUT_RADIO_FAULT);
                        return 1'b1;
                    end
                    return next_fragment(int'(m_frag) + 1, r);
                end
                return 1'b0;
            end
            OP_FRAME: begin
                if (!waiting) return 1'b0;
                if (ev.frame_src != cfg_gateway || ev.frame_seq != m_seq) begin
                    m_noise = 1'b1;
                    return 1'b0;
                end
                if (!ev.parse_ok) begin
                    r = close_session(OUT_MALFORMED);
                    return 1'b1;
                end
                if (m_phase == PH_HELLO_WAIT) begin
                    if (ev.hello_status == HS_BUSY) begin
                        r = close_session(OUT_BUSY);
                        return 1'b1;
                    end
                    if (ev.hello_status != HS_READY) begin
                        r = close_session(OUT_REJECTED);
                        return 1'b1;
                    end
                    m_round = '0;
                    return next_fragment(0, r);
                end
                m_mask = (m_mask | ev.acked_mask) & ALL_RECEIVED;
                if (m_mask == ALL_RECEIVED) begin
                    m_mask         = '0;
                    r              = close_session(OUT_ACKED);
                    r.config_ready = ev.has_config && ev.config_valid;
                    return 1'b1;
                end
                if (m_round >= cfg_retries) begin
                    r = close_session(OUT_PARTIAL);
                    return 1'b1;
                end
                m_round = m_round + 4'd1;
                return next_fragment(0, r);
            end
            OP_MALFORMED: begin
                if (waiting) m_noise = 1'b1;
                return 1'b0;
            end
            OP_TICK: begin
                if (!waiting) return 1'b0;
                if (m_elapsed != ELAPSED_MAX) m_elapsed = m_elapsed + 16'd1;
                limit = (m_phase == PH_HELLO_WAIT) ? cfg_hello_to : cfg_ack_to;
                if (m_elapsed >= limit) begin
                    r = close_session(m_noise ? OUT_MALFORMED : OUT_NO_RESPONSE);
                    return 1'b1;
                end
                return 1'b0;
            end
            default: return 1'b0;
        endcase
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Event builders: every field random unless the caller fixes it
    // ------------------------------------------------------------------

    function automatic t_in_item any_event();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(t_in_item)-1:0];
    endfunction

    function automatic t_in_item quiet_event(input logic [2:0] op);
        t_in_item ev;
        ev        = any_event();
        ev.opcode = op;
        return ev;
    endfunction

    function automatic t_in_item start_event(input logic [7:0] seq, input logic retry,
                                             input logic ok);
        t_in_item ev;
        ev           = quiet_event(OP_START);
        ev.start_seq = seq;
        ev.is_retry  = retry;
        ev.radio_ok  = ok;
        return ev;
    endfunction

    function automatic t_in_item done_event(input logic ok);
        t_in_item ev;
        ev          = quiet_event(OP_SEND_DONE);
        ev.radio_ok = ok;
        return ev;
    endfunction

    // A reply that the current session will accept.
    function automatic t_in_item reply_event(input logic [1:0] status, input logic [15:0] acked,
                                             input logic has_cfg, input logic cfg_ok);
        t_in_item ev;
        ev              = quiet_event(OP_FRAME);
        ev.frame_src    = cfg_gateway;
        ev.frame_seq    = m_seq;
        ev.parse_ok     = 1'b1;
        ev.hello_status = status;
        ev.acked_mask   = acked;
        ev.has_config   = has_cfg;
        ev.config_valid = cfg_ok;
        return ev;
    endfunction

    function automatic logic [15:0] pick_acked();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom);
            1:       return 16'($urandom & $urandom & $urandom);
            2:       return ALL_RECEIVED;
            default: return '0;
        endcase
    endfunction

    function automatic logic [1:0] pick_status();
        if ($urandom_range(0, 3) != 0) return HS_READY;
        return 2'($urandom_range(1, 3));
    endfunction

    // Mostly what a well-behaved radio and gateway would produce in the current phase.
    function automatic t_in_item session_event();
        t_in_item    ev;
        int unsigned r;
        r  = $urandom_range(0, 99);
        ev = any_event();
        case (m_phase)
            PH_IDLE: begin
                if (r < 85)
                    ev = start_event(8'($urandom), 1'($urandom), $urandom_range(0, 19) != 0);
            end
            PH_HELLO_TX, PH_FRAG_TX: begin
                if (r < 88)
                    ev = done_event($urandom_range(0, 29) != 0);
                else if (r < 94)
                    ev = start_event(8'($urandom), 1'($urandom), 1'b1);
            end
            default: begin
                if (r < 35) begin
                    ev = reply_event(pick_status(), pick_acked(), 1'($urandom), 1'($urandom));
                    ev.parse_ok = $urandom_range(0, 15) != 0;
                end else if (r < 50) begin
                    ev = reply_event(pick_status(), pick_acked(), 1'($urandom), 1'($urandom));
                    if ($urandom_range(0, 1) != 0)
                        ev.frame_src = cfg_gateway ^ (16'h1 << $urandom_range(0, 15));
                    else
                        ev.frame_seq = m_seq ^ (8'h1 << $urandom_range(0, 7));
                end else if (r < 58) begin
                    ev.opcode = OP_MALFORMED;
                end else if (r < 90) begin
                    ev.opcode = OP_TICK;
                end else if (r < 94) begin
                    ev = start_event(8'($urandom), 1'($urandom), 1'b1);
                end
            end
        endcase
        return ev;
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Mostly short gaps, now and then a long one; none while steady is set.
    function automatic int pick_gap();
        int unsigned r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Drives one event and books its expected result once the transaction is accepted.
    task automatic send_event(input t_in_item ev);
        int        gap;
        t_out_item res;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            ev_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        ev_ch.valid   <= 1'b1;
        ev_ch.payload <= ev;
        do @(posedge i_clk); while (ev_ch.ready !== 1'b1);
        if (predict_event(ev, res)) pending_results.push_back(res);
    endtask

    // Lets every expected result arrive, then gives the block time to finish silent events.
    task automatic wait_idle();
        @(negedge i_clk);
        ev_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic put_reg(input logic [1:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
    endtask

    task automatic apply_settings(input logic [15:0] gateway, input logic [15:0] hello_to,
                                  input logic [15:0] ack_to, input logic [3:0] retries);
        wait_idle();
        put_reg(CFG_GATEWAY_ID, gateway);
        put_reg(CFG_HELLO_TIMEOUT, hello_to);
        put_reg(CFG_ACK_TIMEOUT, ack_to);
        put_reg(CFG_INNER_RETRIES, {12'h000, retries});
        @(negedge i_clk);
        cfg_we       <= 1'b0;
        cfg_gateway  = gateway;
        cfg_hello_to = hello_to;
        cfg_ack_to   = ack_to;
        cfg_retries  = retries;
    endtask

    // Reports every fragment of the round as sent.
    task automatic finish_round();
        while (m_phase == PH_FRAG_TX) send_event(done_event(1'b1));
    endtask

    // Result side: holds ready high for a while, then stalls for a random gap.
    initial begin
        int gap;
        res_ch.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            res_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            got_res = res_ch.payload;
            if (pending_results.size() == 0) begin
                $error("result transaction with no expectation: action %0d", got_res.action);
                error_count++;
            end else begin
                want_res = pending_results.pop_front();
                check_field("action", 16'(want_res.action), 16'(got_res.action));
                check_field("fragment_index", 16'(want_res.fragment_index),
                            16'(got_res.fragment_index));
                check_field("session_seq_out", 16'(want_res.session_seq_out),
                            16'(got_res.session_seq_out));
                check_field("retry_flag", 16'(want_res.retry_flag), 16'(got_res.retry_flag));
                check_field("outcome", 16'(want_res.outcome), 16'(got_res.outcome));
                check_field("config_ready", 16'(want_res.config_ready),
                            16'(got_res.config_ready));
                check_field("mask_status", want_res.mask_status, got_res.mask_status);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Radio not ready at start, a hello with the retry flag, and a failed hello send.
    task automatic test_radio_faults();
        send_event(start_event(8'h00, 1'b0, 1'b0));
        send_event(start_event(8'hFF, 1'b1, 1'b1));
        send_event(done_event(1'b0));
    endtask

    // A start abandons the running session; stray and unused events change nothing.
    task automatic test_ignored_events();
        t_in_item ev;
        send_event(start_event(8'h12, 1'b0, 1'b1));
        send_event(start_event(8'h34, 1'b1, 1'b1));
        send_event(quiet_event(OP_TICK));
        send_event(reply_event(HS_READY, ALL_RECEIVED, 1'b1, 1'b1));
        send_event(quiet_event(OP_MALFORMED));
        for (int op = int'(OP_TICK) + 1; op < 8; op++) send_event(quiet_event(3'(op)));
        send_event(done_event(1'b1));
        send_event(done_event(1'b0));
        ev = reply_event(HS_READY, ALL_RECEIVED, 1'b1, 1'b1);
        ev.frame_seq = ~m_seq;
        send_event(ev);
        send_event(reply_event(HS_BUSY, '0, 1'b0, 1'b0));
    endtask

    // Rejected hello, the reserved status value and a reply that fails to parse.
    task automatic test_hello_rejects();
        t_in_item ev;
        send_event(start_event(8'h01, 1'b0, 1'b1));
        send_event(done_event(1'b1));
        send_event(reply_event(HS_REJECTED, '0, 1'b0, 1'b0));
        send_event(start_event(8'h02, 1'b1, 1'b1));
        send_event(done_event(1'b1));
        send_event(reply_event(HS_RESERVED, '0, 1'b0, 1'b0));
        send_event(start_event(8'h03, 1'b0, 1'b1));
        send_event(done_event(1'b1));
        ev = reply_event(HS_READY, '0, 1'b0, 1'b0);
        ev.parse_ok = 1'b0;
        send_event(ev);
    endtask

    // Zero and one tick windows, a failed fragment send, a partial round and mask carry-over.
    task automatic test_short_windows();
        apply_settings(16'hFFFF, 16'd0, 16'd1, 4'd0);
        send_event(start_event(8'h80, 1'b0, 1'b1));
        send_event(done_event(1'b1));
        send_event(quiet_event(OP_TICK));
        send_event(start_event(8'h81, 1'b0, 1'b1));
        send_event(done_event(1'b1));
        send_event(quiet_event(OP_MALFORMED));
        send_event(quiet_event(OP_TICK));
        send_event(start_event(8'h82, 1'b0, 1'b1));
        send_event(done_event(1'b1));
        send_event(reply_event(HS_READY, '0, 1'b0, 1'b0));
        send_event(done_event(1'b0));
        send_event(start_event(8'h83, 1'b1, 1'b1));
        send_event(done_event(1'b1));
        send_event(reply_event(HS_READY, '0, 1'b0, 1'b0));
        finish_round();
        send_event(reply_event(HS_READY, 16'h00F0, 1'b1, 1'b1));
        send_event(start_event(8'h84, 1'b0, 1'b1));
        send_event(done_event(1'b1));
        send_event(reply_event(HS_READY, '0, 1'b0, 1'b0));
        finish_round();
        send_event(quiet_event(OP_TICK));
    endtask

    // A long hello window runs out tick by tick, then the most retries reach a full acknowledge.
    task automatic test_long_window();
        apply_settings(16'h0000, 16'd100, 16'hFFFF, 4'd15);
        steady = 1'b1;
        send_event(start_event(8'hC0, 1'b0, 1'b1));
        send_event(done_event(1'b1));
        repeat (100) send_event(quiet_event(OP_TICK));
        send_event(start_event(8'hC1, 1'b0, 1'b1));
        send_event(done_event(1'b1));
        send_event(reply_event(HS_READY, '0, 1'b0, 1'b0));
        finish_round();
        send_event(reply_event(HS_READY, 16'h0F0F, 1'b0, 1'b0));
        finish_round();
        send_event(reply_event(HS_READY, ALL_RECEIVED, 1'b1, 1'b1));
        steady = 1'b0;
    endtask

    // Random sessions under several register settings.
    task automatic test_random_sessions();
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: apply_settings(16'($urandom), 16'($urandom_range(1, 6)),
                                  16'($urandom_range(1, 6)), 4'($urandom_range(0, 3)));
                1: apply_settings(16'hFFFF, 16'd1, 16'd1, 4'd0);
                2: apply_settings(16'h0000, 16'd4, 16'd7, 4'd15);
                default: apply_settings(16'($urandom), 16'($urandom_range(2, 9)),
                                        16'($urandom_range(2, 9)), 4'($urandom_range(0, 15)));
            endcase
            for (int n = 0; n < 400; n++) begin
                if (n % 50 == 0) steady = ($urandom_range(0, 3) == 0);
                send_event(session_event());
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = '0;
        cfg_data      = '0;
        ev_ch.valid   = 1'b0;
        ev_ch.payload = '0;
        reset_session_model();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_radio_faults();
        test_ignored_events();
        test_hello_rejects();
        test_short_windows();
        test_long_window();
        test_random_sessions();

        wait_idle();
        if (error_count == 0)
            $display("fragment_burst_session_arq_core test passed");
        else
            $display("fragment_burst_session_arq_core test failed");
        $finish;
    end

endmodule
